### rtl/core/sdcd_pkg.sv
package sdcd_pkg;

   // Field widths
   localparam int unsigned HZ_W      = 28;
   localparam int unsigned PCODE_W   = 8;
   localparam int unsigned DCODE_W   = 4;
   localparam int unsigned FIELD_W   = 16;

   // (target + 1) scaled by the prescaler: up to 2^28 * 256
   localparam int unsigned BASE_W    = 37;
   // base scaled by the divisor or by sixteen: up to 2^36 * 16
   localparam int unsigned ACC_W     = 41;
   localparam int unsigned PRE_LOG_W = 4;

   localparam logic [PRE_LOG_W-1:0] PRE_LOG_MAX = 4'd8;
   localparam logic [DCODE_W-1:0]   DCODE_MAX   = 4'd15;
   localparam logic [HZ_W-1:0]      SRC_RESET   = 28'd200000000;

   // Sequencer to datapath
   typedef struct packed {
      logic load;
      logic pre_step;
      logic div_start;
      logic div_step;
      logic div_phase;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic                 pre_more;
      logic                 div_more;
      logic [PCODE_W-1:0]   pcode;
      logic [DCODE_W-1:0]   dcode;
   } status_type;

endpackage

### rtl/core/sdcd_search_dp.sv
module sdcd_search_dp (
   input  logic                              clock,
   input  sdcd_pkg::ctrl_type                ctrl,
   input  logic [sdcd_pkg::HZ_W-1:0]         src_hz,
   input  logic [sdcd_pkg::HZ_W-1:0]         target_hz,
   output sdcd_pkg::status_type              status
);

   logic [sdcd_pkg::BASE_W-1:0]    base_ff, base_in;
   logic [sdcd_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic [sdcd_pkg::PRE_LOG_W-1:0] pre_log_ff, pre_log_in;
   logic [sdcd_pkg::DCODE_W-1:0]   dcode_ff, dcode_in;

   logic [sdcd_pkg::ACC_W-1:0]     base_ext;
   logic [sdcd_pkg::ACC_W-1:0]     cmp_op;
   logic [sdcd_pkg::ACC_W-1:0]     add_a;
   logic [sdcd_pkg::ACC_W-1:0]     sum;
   logic [sdcd_pkg::ACC_W-1:0]     src_ext;
   logic                           hit;

   assign base_ext = {{(sdcd_pkg::ACC_W-sdcd_pkg::BASE_W){1'b0}}, base_ff};
   assign src_ext  = {{(sdcd_pkg::ACC_W-sdcd_pkg::HZ_W){1'b0}}, src_hz};

   // Shared unit: one compare against the source rate and one adder.
   // floor(src / m) > target holds exactly when src >= (target + 1) * m.
   assign cmp_op = ctrl.div_phase ? acc_ff : {base_ff, 4'b0000};
   assign hit    = src_ext >= cmp_op;
   assign add_a  = ctrl.div_phase ? acc_ff : base_ext;
   assign sum    = add_a + base_ext;

   assign status.pre_more = hit && (pre_log_ff != sdcd_pkg::PRE_LOG_MAX);
   assign status.div_more = hit && (dcode_ff != sdcd_pkg::DCODE_MAX);
   assign status.dcode    = dcode_ff;
   assign status.pcode    = (pre_log_ff == '0) ? '0 :
      sdcd_pkg::PCODE_W'(1) << (pre_log_ff - sdcd_pkg::PRE_LOG_W'(1));

   // Next values of the search registers
   always_comb begin
      base_in    = base_ff;
      acc_in     = acc_ff;
      pre_log_in = pre_log_ff;
      dcode_in   = dcode_ff;
      if (ctrl.load) begin
         base_in    = {{(sdcd_pkg::BASE_W-sdcd_pkg::HZ_W){1'b0}}, target_hz}
                      + sdcd_pkg::BASE_W'(1);
         pre_log_in = '0;
         dcode_in   = '0;
      end else if (ctrl.pre_step) begin
         // double the prescaler
         base_in    = sum[sdcd_pkg::BASE_W-1:0];
         pre_log_in = pre_log_ff + sdcd_pkg::PRE_LOG_W'(1);
      end else if (ctrl.div_start) begin
         acc_in     = base_ext;
         dcode_in   = '0;
      end else if (ctrl.div_step) begin
         // advance the divisor by one
         acc_in     = sum;
         dcode_in   = dcode_ff + sdcd_pkg::DCODE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      pre_log_ff <= pre_log_in;
      dcode_ff   <= dcode_in;
   end

endmodule

### rtl/core/sd_clock_divider_select.sv
// Card clock prescaler and divisor selection.
// Configuration: csr_wr_en with csr_wr_data sets the source clock rate in
// hertz; reset loads 200 MHz. Write it only while no request is in flight.
// Request channel: req_valid with req_target_clock_hz; a transfer happens on
// a clock edge with req_valid high and req_stall low. req_stall is high from
// the transfer until the search has finished and its result is registered.
// Response channel: rsp_valid with prescaler code, divisor code and packed
// clock field; a transfer happens with rsp_valid high and rsp_stall low.
// The search doubles the prescaler one step per cycle, then steps the
// divisor one per cycle, all on one shared compare and add unit, and
// then writes the result to the output register. One request is worked
// on at a time; a new one is taken only once the last result is registered.
// While the receiver stalls the result waits in the output register and a
// new request may be taken and searched; it then waits until the output
// register is free. Synchronous reset empties the pipeline and drops any
// pending result.
module sd_clock_divider_select (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sdcd_pkg::HZ_W-1:0]        csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sdcd_pkg::HZ_W-1:0]        req_target_clock_hz,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sdcd_pkg::PCODE_W-1:0]     rsp_prescaler_code,
   output logic [sdcd_pkg::DCODE_W-1:0]     rsp_divisor_code,
   output logic [sdcd_pkg::FIELD_W-1:0]     rsp_clock_field
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PRE  = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [sdcd_pkg::HZ_W-1:0]     src_ff, src_in;
   logic [sdcd_pkg::HZ_W-1:0]     target_ff, target_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sdcd_pkg::PCODE_W-1:0]  pcode_ff, pcode_in;
   logic [sdcd_pkg::DCODE_W-1:0]  dcode_ff, dcode_in;

   sdcd_pkg::ctrl_type            ctrl;
   sdcd_pkg::status_type          status;
   logic                          req_xfer;
   logic                          out_free;
   logic                          out_load;

   assign req_xfer = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == S_OUT) && out_free;

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prescaler_code = pcode_ff;
   assign rsp_divisor_code   = dcode_ff;
   assign rsp_clock_field    = {pcode_ff, dcode_ff, 4'b0000};

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      ctrl.load      = 1'b0;
      ctrl.pre_step  = 1'b0;
      ctrl.div_start = 1'b0;
      ctrl.div_step  = 1'b0;
      ctrl.div_phase = (state_ff == S_DIV);
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               ctrl.load = 1'b1;
               state_in  = S_PRE;
            end
         end
         S_PRE: begin
            if (status.pre_more) begin
               ctrl.pre_step = 1'b1;
            end else begin
               ctrl.div_start = 1'b1;
               state_in       = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_more) begin
               ctrl.div_step = 1'b1;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration, captured request and output register
   always_comb begin
      src_in       = csr_wr_en ? csr_wr_data : src_ff;
      target_in    = req_xfer ? req_target_clock_hz : target_ff;
      rsp_valid_in = rsp_valid_ff;
      pcode_in     = pcode_ff;
      dcode_in     = dcode_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         pcode_in     = status.pcode;
         dcode_in     = status.dcode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         src_ff       <= sdcd_pkg::SRC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff <= target_in;
      pcode_ff  <= pcode_in;
      dcode_ff  <= dcode_in;
   end

   sdcd_search_dp u_search_dp (
      .clock     (clock),
      .ctrl      (ctrl),
      .src_hz    (src_ff),
      .target_hz (req_xfer ? req_target_clock_hz : target_ff),
      .status    (status)
   );

   // Prescaler code is zero or a single power of two
   a_pcode_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_prescaler_code))
      else $error("prescaler code is not a power of two");

   // Divisor search never wraps its counter
   a_div_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && ctrl.div_step) |=> (status.dcode != '0))
      else $error("divisor code wrapped");

   // Leaving the prescaler search always enters the divisor search
   a_pre_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PRE && !status.pre_more) |=> (state_ff == S_DIV))
      else $error("prescaler search did not hand over to divisor search");

   // A result is only loaded into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending result overwritten");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned NUM_PHASES     = 10;
   localparam int unsigned ITEMS_PER_PHASE = 200;
   localparam int unsigned HOLDOFF_PHASE  = 4;
   localparam int unsigned PAUSE_PHASE    = 6;
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned LIMIT_CYCLES   = 400000;

   // Search bounds of the prescaler and divisor
   localparam longint unsigned PRE_BASE  = 16;
   localparam longint unsigned PRE_LIMIT = 256;
   localparam longint unsigned DIV_LIMIT = 16;

   localparam logic [sdcd_pkg::HZ_W-1:0] HZ_MAX = '1;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [sdcd_pkg::HZ_W-1:0]    target;
      logic [sdcd_pkg::PCODE_W-1:0] prescaler;
      logic [sdcd_pkg::DCODE_W-1:0] divisor;
      logic [sdcd_pkg::FIELD_W-1:0] field;
   } clk_choice_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [sdcd_pkg::HZ_W-1:0]     csr_wr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [sdcd_pkg::HZ_W-1:0]     req_target_clock_hz = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [sdcd_pkg::PCODE_W-1:0]  rsp_prescaler_code;
   logic [sdcd_pkg::DCODE_W-1:0]  rsp_divisor_code;
   logic [sdcd_pkg::FIELD_W-1:0]  rsp_clock_field;

   logic [sdcd_pkg::HZ_W-1:0]     target_queue [$];
   clk_choice_type                choice_queue [$];
   logic [sdcd_pkg::HZ_W-1:0]     source_hz = sdcd_pkg::SRC_RESET;
   logic                          req_done = 1'b0;
   logic                          long_hold = 1'b0;
   logic                          holdoff_go = 1'b0;
   int unsigned                   send_idle_pct = 0;
   int unsigned                   rsp_stall_pct = 0;
   int unsigned                   mismatch_count = 0;
   int unsigned                   cycle_count = 0;

   sd_clock_divider_select u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_target_clock_hz (req_target_clock_hz),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_prescaler_code  (rsp_prescaler_code),
      .rsp_divisor_code    (rsp_divisor_code),
      .rsp_clock_field     (rsp_clock_field)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Double the prescaler, then step the divisor, as the card clock search does
   function automatic clk_choice_type select_divider(
         input logic [sdcd_pkg::HZ_W-1:0] src,
         input logic [sdcd_pkg::HZ_W-1:0] tgt);
      longint unsigned s;
      longint unsigned t;
      longint unsigned pre;
      longint unsigned dv;
      clk_choice_type  c;
      s   = src;
      t   = tgt;
      pre = 1;
      dv  = 1;
      while ((s / (PRE_BASE * pre)) > t && pre < PRE_LIMIT)
         pre = pre << 1;
      while ((s / (dv * pre)) > t && dv < DIV_LIMIT)
         dv = dv + 1;
      c.target    = tgt;
      c.prescaler = sdcd_pkg::PCODE_W'(pre >> 1);
      c.divisor   = sdcd_pkg::DCODE_W'(dv - 1);
      c.field     = {c.prescaler, c.divisor, 4'b0000};
      return c;
   endfunction

   // Mostly targets near a prescaler or divisor boundary of the current source
   function automatic logic [sdcd_pkg::HZ_W-1:0] pick_target(
         input logic [sdcd_pkg::HZ_W-1:0] src);
      longint v;
      longint unsigned pw;
      longint unsigned dv;
      pw = longint'(1) << $urandom_range(0, 8);
      dv = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
         0, 1: v = $urandom & HZ_MAX;
         2, 3: v = $urandom & ((32'd1 << $urandom_range(1, sdcd_pkg::HZ_W)) - 1);
         4, 5: v = longint'(longint'(src) / longint'(PRE_BASE * pw))
                   + longint'(int'($urandom_range(0, 4)) - 2);
         default: v = longint'(longint'(src) / longint'(dv * pw))
                      + longint'(int'($urandom_range(0, 4)) - 2);
      endcase
      if (v < 1)
         v = 1;
      if (v > longint'(HZ_MAX))
         v = longint'(HZ_MAX);
      return sdcd_pkg::HZ_W'(v);
   endfunction

   // Spread sources over many magnitudes, never zero
   function automatic logic [sdcd_pkg::HZ_W-1:0] pick_source();
      logic [sdcd_pkg::HZ_W-1:0] v;
      v = sdcd_pkg::HZ_W'($urandom & ((32'd1 << $urandom_range(1, sdcd_pkg::HZ_W)) - 1));
      if (v == '0)
         v = 1;
      return v;
   endfunction

   task automatic check_field(input string name, input logic [sdcd_pkg::HZ_W-1:0] tgt,
                              input logic [sdcd_pkg::FIELD_W-1:0] want,
                              input logic [sdcd_pkg::FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch for target %0d: expected %0d, got %0d",
                  $time, name, tgt, want, got);
         mismatch_count++;
      end
   endtask

   // Hold until nothing is queued, offered or outstanding; look at the
   // rising edge, when the driver's last change has settled
   task automatic wait_idle();
      @(posedge clock);
      while (target_queue.size() != 0 || (req_valid && !req_done) ||
             choice_queue.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_source(input logic [sdcd_pkg::HZ_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      source_hz    = v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= sdcd_pkg::HZ_W'($urandom);
   endtask

   task automatic set_idle(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 68 : (mode == IDLE_BOTH) ? 14 : 0;
      rsp_stall_pct = (mode == IDLE_RECEIVER) ? 68 : (mode == IDLE_BOTH) ? 14 : 0;
   endtask

   // Offer the next transfer once the previous one has gone
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (target_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid           <= 1'b1;
            req_target_clock_hz <= target_queue.pop_front();
         end else begin
            req_valid           <= 1'b0;
            req_target_clock_hz <= sdcd_pkg::HZ_W'($urandom);
         end
      end
   end

   // Stall the result channel at random or for the long hold-off
   always @(negedge clock) begin
      rsp_stall <= !reset && (long_hold || $urandom_range(0, 99) < rsp_stall_pct);
   end

   // Long receiver hold-off while the sender keeps offering
   initial begin
      wait (holdoff_go);
      @(negedge clock);
      long_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(negedge clock);
      long_hold <= 1'b0;
   end

   // Predict on each request transfer, check each result transfer
   always @(posedge clock) begin : monitor
      clk_choice_type want;
      req_done <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            choice_queue.push_back(select_divider(source_hz, req_target_clock_hz));
         if (rsp_valid && !rsp_stall) begin
            if (choice_queue.size() == 0) begin
               $display("%0t: result with nothing expected: pcode %0d dcode %0d field %h",
                        $time, rsp_prescaler_code, rsp_divisor_code, rsp_clock_field);
               mismatch_count++;
            end else begin
               want = choice_queue.pop_front();
               check_field("prescaler_code", want.target,
                           sdcd_pkg::FIELD_W'(want.prescaler),
                           sdcd_pkg::FIELD_W'(rsp_prescaler_code));
               check_field("divisor_code", want.target,
                           sdcd_pkg::FIELD_W'(want.divisor),
                           sdcd_pkg::FIELD_W'(rsp_divisor_code));
               check_field("clock_field", want.target, want.field, rsp_clock_field);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d results outstanding", $time, choice_queue.size());
         $display("sd_clock_divider_select test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned directed_hz [22] = '{
         1, 2, 268435455, 200000000, 200000001, 199999999, 100000000,
         12500000, 12499999, 781250, 781249, 48828, 48827, 48829, 3052,
         400000, 25000000, 50000000, 52083, 134217728, 89478485, 178956970
      };
      logic [sdcd_pkg::HZ_W-1:0] src;
      int unsigned n;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         set_idle(idle_mode_type'(ph % 4));
         // Pick the source rate for this phase, extremes first
         case (ph)
            0: src = sdcd_pkg::SRC_RESET;
            1: src = HZ_MAX;
            2: src = 1;
            3: src = 200000000;
            4: src = 50000000;
            9: src = sdcd_pkg::SRC_RESET;
            default: src = pick_source();
         endcase
         if (ph != 0)
            write_source(src);
         if (ph == 0) begin
            foreach (directed_hz[i])
               target_queue.push_back(sdcd_pkg::HZ_W'(directed_hz[i]));
         end
         if (ph == HOLDOFF_PHASE)
            holdoff_go = 1'b1;
         n = (ph == 2) ? ITEMS_PER_PHASE / 4 : ITEMS_PER_PHASE;
         for (int i = 0; i < n; i++) begin
            target_queue.push_back(pick_target(source_hz));
            // Pause the sender half-way until every result is back
            if (ph == PAUSE_PHASE && i == n / 2)
               wait_idle();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && choice_queue.size() == 0) begin
         $display("sd_clock_divider_select test passed");
      end else begin
         $display("sd_clock_divider_select test failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/sdcd_pkg.sv
rtl/core/sdcd_search_dp.sv
rtl/core/sd_clock_divider_select.sv
tb/tb.sv
